// File: sv/tre_pkg.sv
package tre_pkg;

  localparam int NumRegs = 8;
  localparam int RegIdxBits = 3;

  typedef enum logic [RegIdxBits-1:0] {
    REG_EXT_X_MIN = 3'd0,
    REG_EXT_X_MAX = 3'd1,
    REG_EXT_Y_MIN = 3'd2,
    REG_EXT_Y_MAX = 3'd3,
    REG_TILE_W    = 3'd4,
    REG_TILE_H    = 3'd5,
    REG_COLUMNS   = 3'd6,
    REG_ROWS      = 3'd7
  } reg_idx_t;

endpackage

// File: sv/tre_div.sv
// Pipelined restoring divider with one quotient bit per stage, then a clamp
// of the quotient to cap. Stalls with the enclosing pipe via en.
module tre_div import tre_pkg::*; #(
  parameter int W  = 40,
  parameter int IB = 30
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  span,
  input  logic [IB-1:0] cap,
  output logic [IB-1:0] index
);

  logic [W-1:0] rem [W+1];
  logic [W-1:0] quo [W+1];
  logic [W-1:0] dsr [W+1];
  logic [IB-1:0] cp [W+1];

  assign rem[0] = '0;
  assign quo[0] = num;
  assign dsr[0] = span;
  assign cp[0]  = cap;

  for (genvar s = 0; s < W; s++) begin : g_st
    logic [W:0] trial;
    logic [W:0] shifted;
    assign shifted = {rem[s], quo[s][W-1]};
    assign trial   = shifted - {1'b0, dsr[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[W]) begin
          rem[s+1] <= trial[W-1:0];
        end else begin
          rem[s+1] <= shifted[W-1:0];
        end
        quo[s+1] <= {quo[s][W-2:0], ~trial[W]};
        dsr[s+1] <= dsr[s];
        cp[s+1]  <= cp[s];
      end
    end
  end

  logic big;
  assign big = (W > IB) ? (quo[W] >> IB) != '0 : 1'b0;
  always_ff @(posedge clk) begin
    if (en) begin
      if (big || quo[W][IB-1:0] > cp[W]) begin
        index <= cp[W];
      end else begin
        index <= quo[W][IB-1:0];
      end
    end
  end

endmodule

// File: sv/tre_clamp.sv
// Clamp corners to the extent and form the four distances.
module tre_clamp import tre_pkg::*; #(
  parameter int W = 40
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] ex_lo,
  input  logic signed [W-1:0] ex_hi,
  input  logic signed [W-1:0] ey_lo,
  input  logic signed [W-1:0] ey_hi,
  input  logic signed [W-1:0] x0,
  input  logic signed [W-1:0] y0,
  input  logic signed [W-1:0] x1,
  input  logic signed [W-1:0] y1,
  output logic                empty,
  output logic [W-1:0]        dx0,
  output logic [W-1:0]        dx1,
  output logic [W-1:0]        dy1,
  output logic [W-1:0]        dy0
);

  logic signed [W-1:0] cx0, cx1, cy0, cy1;
  logic inv;

  // first stage: clamp
  always_ff @(posedge clk) begin
    if (en) begin
      inv <= (ex_lo > ex_hi) || (ey_lo > ey_hi);
      cx0 <= (x0 < ex_lo) ? ex_lo : (x0 > ex_hi) ? ex_hi : x0;
      cx1 <= (x1 < ex_lo) ? ex_lo : (x1 > ex_hi) ? ex_hi : x1;
      cy0 <= (y0 < ey_lo) ? ey_lo : (y0 > ey_hi) ? ey_hi : y0;
      cy1 <= (y1 < ey_lo) ? ey_lo : (y1 > ey_hi) ? ey_hi : y1;
    end
  end

  // second stage: emptiness and offsets (fit in W bits unsigned)
  always_ff @(posedge clk) begin
    if (en) begin
      empty <= inv || (cx0 >= cx1) || (cy0 >= cy1);
      dx0 <= W'(cx0 - ex_lo);
      dx1 <= W'(cx1 - ex_lo);
      dy1 <= W'(ey_hi - cy1);
      dy0 <= W'(ey_hi - cy0);
    end
  end

endmodule

// File: sv/tile_range_from_extent.sv
// Channel | dir | beat contents
// s_axis  | in  | tdata: rect_x_min, rect_y_min, rect_x_max, rect_y_max
// m_axis  | out | tdata: range_empty, first_column, last_column, first_row, last_row
// cfg     | in  | cfg_index, cfg_data
// One rectangle per cycle unless stalled, through the clamp stages, the
// bit-per-stage dividers and the index clamp register. The whole pipe
// advances while the output register is empty or being taken, so a stall holds every stage.
// Reset clears valid bits and the registers to their reset values.
module tile_range_from_extent import tre_pkg::*; #(
  parameter int COORD_BITS    = 40,
  parameter int FRACTION_BITS = 8,
  parameter int INDEX_BITS    = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata, // x_min,y_min,x_max,y_max
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // range_empty, first_column, last_column, first_row, last_row
  output logic [((1+4*INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [RegIdxBits-1:0] cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int W = COORD_BITS;
  localparam int IB = INDEX_BITS;
  localparam int Lat = W + 3;
  localparam int OutW = ((1+4*IB+7)/8)*8;
  localparam logic [W-2:0] SpanReset = (W-1)'(1) << FRACTION_BITS;

  logic signed [W-1:0] ex_lo, ex_hi, ey_lo, ey_hi;
  logic [W-2:0] span_w, span_h;
  logic [IB:0] cols, rows;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_lo <= '0; ex_hi <= '0; ey_lo <= '0; ey_hi <= '0;
      span_w <= SpanReset; span_h <= SpanReset;
      cols <= (IB+1)'(1); rows <= (IB+1)'(1);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EXT_X_MIN: ex_lo <= cfg_data;
        REG_EXT_X_MAX: ex_hi <= cfg_data;
        REG_EXT_Y_MIN: ey_lo <= cfg_data;
        REG_EXT_Y_MAX: ey_hi <= cfg_data;
        REG_TILE_W:    span_w <= cfg_data[W-2:0];
        REG_TILE_H:    span_h <= cfg_data[W-2:0];
        REG_COLUMNS:   cols <= cfg_data[IB:0];
        REG_ROWS:      rows <= cfg_data[IB:0];
        default: ;
      endcase
    end
  end

  // effective divisors and index caps
  logic [W-1:0] dw, dh;
  logic [IB-1:0] cap_c, cap_r;
  assign dw = (span_w == '0) ? W'(1) : {1'b0, span_w};
  assign dh = (span_h == '0) ? W'(1) : {1'b0, span_h};
  assign cap_c = (cols == '0) ? '0 : cols[IB] ? '1 : IB'(cols - 1'b1);
  assign cap_r = (rows == '0) ? '0 : rows[IB] ? '1 : IB'(rows - 1'b1);

  logic en;
  logic [Lat-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld[Lat-1];

  logic empty;
  logic [W-1:0] dx0, dx1, dy1, dy0;
  tre_clamp #(.W(W)) u_clamp (
    .clk, .en, .ex_lo, .ex_hi, .ey_lo, .ey_hi,
    .x0(s_axis_tdata[W-1:0]), .y0(s_axis_tdata[2*W-1:W]),
    .x1(s_axis_tdata[3*W-1:2*W]), .y1(s_axis_tdata[4*W-1:3*W]),
    .empty, .dx0, .dx1, .dy1, .dy0
  );

  // matches the W divider stages plus the index clamp register
  logic [W+1:0] emp_d;
  assign emp_d[0] = empty;
  for (genvar i = 0; i < W + 1; i++) begin : g_emp
    always_ff @(posedge clk) if (en) emp_d[i+1] <= emp_d[i];
  end

  logic [IB-1:0] fc, lc, fr, lr;
  tre_div #(.W(W), .IB(IB)) u_fc (.clk, .en, .num(dx0), .span(dw), .cap(cap_c), .index(fc));
  tre_div #(.W(W), .IB(IB)) u_lc (.clk, .en, .num(dx1), .span(dw), .cap(cap_c), .index(lc));
  tre_div #(.W(W), .IB(IB)) u_fr (.clk, .en, .num(dy1), .span(dh), .cap(cap_r), .index(fr));
  tre_div #(.W(W), .IB(IB)) u_lr (.clk, .en, .num(dy0), .span(dh), .cap(cap_r), .index(lr));

  logic e;
  assign e = emp_d[W+1];
  assign m_axis_tdata = OutW'({e ? IB'(0) : lr, e ? IB'(0) : fr,
                               e ? IB'(0) : lc, e ? IB'(0) : fc, e});

endmodule

// File: sv/tre_checker.sv
module tre_checker import tre_pkg::*; (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[120:1] == '0)
    else $error("empty result with indices");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind tile_range_from_extent tre_checker u_chk (
  .clk, .rst, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata(m_axis_tdata)
);
